>>> hw/rtl/lfu_pkg.sv
// shared types and constants for the lfu cache table
package lfu_pkg;

	localparam int MAX_ENTRIES_DEF = 16;
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CNT_W = 32;
	localparam int STAMP_W = 64;
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef struct packed {
		logic operation;
		logic [KEY_W-1:0] lookup_key;
		logic signed [VAL_W-1:0] store_value;
	} req_t;

	typedef struct packed {
		logic key_found;
		logic signed [VAL_W-1:0] read_value;
		logic entry_evicted;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		logic [CNT_W-1:0] count;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic cap_zero;
		logic scan_last;
		logic out_busy;
	} status_t;

endpackage

>>> hw/rtl/lfu_ram.sv
// generic single write port ram with registered read
module lfu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic clk,
	input  logic we,
	input  logic [AW-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hw/rtl/lfu_ctrl.sv
// request sequencer: accept, scan, drain, commit
module lfu_ctrl import lfu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  status_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = sts.cap_zero ? ST_COMMIT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (!sts.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_stall = (state_q != ST_IDLE);
		cmd.start = (state_q == ST_IDLE) && req_valid;
		cmd.scan = (state_q == ST_SCAN);
		cmd.commit = (state_q == ST_COMMIT) && !sts.out_busy;
	end

endmodule

>>> hw/rtl/lfu_dp.sv
// datapath: entry store, scan for hit and victim, write-back and result register
module lfu_dp import lfu_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [CAP_W-1:0] cfg_wr_data,
	input  req_t req,
	input  cmd_t cmd,
	output status_t sts,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int FW = $clog2(MAX_ENTRIES + 1);
	localparam int CW = (FW > CAP_W) ? FW : CAP_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);
	localparam logic [FW-1:0] FILL_MAX = FW'(MAX_ENTRIES);

	logic [CAP_W-1:0] cap_q;
	req_t req_q;
	logic zero_q;
	logic [STAMP_W-1:0] stamp_q;
	logic [MAX_ENTRIES-1:0] valid_q;

	logic [IW-1:0] rd_idx_q;
	logic chk_s1;
	logic [IW-1:0] idx_s1;
	entry_t rd_entry;

	logic [FW-1:0] fill_q;
	logic hit_q;
	logic [IW-1:0] hit_idx_q;
	logic [VAL_W-1:0] hit_val_q;
	logic [CNT_W-1:0] hit_cnt_q;
	logic vic_found_q;
	logic [IW-1:0] vic_idx_q;
	logic [CNT_W-1:0] vic_cnt_q;
	logic [STAMP_W-1:0] vic_stamp_q;
	logic free_found_q;
	logic [IW-1:0] free_idx_q;

	logic rsp_valid_q;
	rsp_t rsp_q;

	logic full;
	logic is_put;
	logic do_update;
	logic do_insert;
	logic wr_en;
	logic [IW-1:0] wr_idx;
	entry_t wr_entry;
	logic better;

	assign sts.cap_zero = (cap_q == '0);
	assign sts.scan_last = (rd_idx_q == LAST_IDX);
	assign sts.out_busy = rsp_valid_q && rsp_stall;

	lfu_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_ENTRIES)
	) u_store (
		.clk(clk),
		.we(wr_en),
		.waddr(wr_idx),
		.wdata(wr_entry),
		.re(cmd.scan),
		.raddr(rd_idx_q),
		.rdata(rd_entry)
	);

	// capacity above the store size behaves as the store size
	assign full = (CW'(fill_q) >= CW'(cap_q)) || (fill_q == FILL_MAX);
	assign is_put = (req_q.operation == OP_PUT);
	assign do_update = !zero_q && hit_q;
	assign do_insert = !zero_q && !hit_q && is_put &&
		((full && vic_found_q) || (!full && free_found_q));

	always_comb begin
		wr_en = cmd.commit && (do_update || do_insert);
		wr_idx = hit_idx_q;
		wr_entry.key = req_q.lookup_key;
		wr_entry.value = req_q.store_value;
		wr_entry.count = CNT_W'(1);
		wr_entry.stamp = stamp_q;
		if (hit_q) begin
			wr_idx = hit_idx_q;
			wr_entry.value = is_put ? req_q.store_value : hit_val_q;
			wr_entry.count = (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + CNT_W'(1);
		end else if (full) begin
			wr_idx = vic_idx_q;
		end else begin
			wr_idx = free_idx_q;
		end
	end

	// strict compare keeps the lowest index on a tie
	assign better = !vic_found_q || (rd_entry.count < vic_cnt_q) ||
		((rd_entry.count == vic_cnt_q) && (rd_entry.stamp < vic_stamp_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q <= 1'b0;
			rd_idx_q <= '0;
			chk_s1 <= 1'b0;
			idx_s1 <= '0;
		end else begin
			chk_s1 <= cmd.scan;
			idx_s1 <= rd_idx_q;
			if (cmd.start) begin
				zero_q <= sts.cap_zero;
				rd_idx_q <= '0;
			end else if (cmd.scan) begin
				rd_idx_q <= rd_idx_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			hit_q <= 1'b0;
			vic_found_q <= 1'b0;
			free_found_q <= 1'b0;
		end else if (cmd.start) begin
			fill_q <= '0;
			hit_q <= 1'b0;
			vic_found_q <= 1'b0;
			free_found_q <= 1'b0;
		end else if (chk_s1) begin
			if (valid_q[idx_s1]) begin
				fill_q <= fill_q + FW'(1);
				if (!hit_q && (rd_entry.key == req_q.lookup_key)) begin
					hit_q <= 1'b1;
				end
				if (better) begin
					vic_found_q <= 1'b1;
				end
			end else if (!free_found_q) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chk_s1) begin
			if (valid_q[idx_s1]) begin
				if (!hit_q && (rd_entry.key == req_q.lookup_key)) begin
					hit_idx_q <= idx_s1;
					hit_val_q <= rd_entry.value;
					hit_cnt_q <= rd_entry.count;
				end
				if (better) begin
					vic_idx_q <= idx_s1;
					vic_cnt_q <= rd_entry.count;
					vic_stamp_q <= rd_entry.stamp;
				end
			end else if (!free_found_q) begin
				free_idx_q <= idx_s1;
			end
		end
	end

	// an evicted slot is refilled at once, so its valid bit stays set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			stamp_q <= '0;
		end else if (cmd.commit && !zero_q) begin
			stamp_q <= stamp_q + STAMP_W'(1);
			if (do_insert) begin
				valid_q[wr_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q.key_found <= do_update;
			rsp_q.read_value <= (do_update && !is_put) ? hit_val_q : '0;
			rsp_q.entry_evicted <= do_insert && full;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

>>> hw/rtl/lfu_cache_table.sv
// lfu cache table top level: key-value cache with least-frequently-used replacement
//
// requests come in on req/req_valid and are taken when req_stall is low; each request
// is a get or a put. one response per request leaves on rsp/rsp_valid and is taken
// when rsp_stall is low. the user must write cache_capacity through cfg_wr_en/cfg_wr_data
// while no request is in flight (the block does not enforce it); zero disables the cache.
//
// every request with nonzero capacity sweeps the entry ram once, one entry per cycle
// through its read port, looking for the key and for the entry with the smallest
// (count, stamp). the sequence is accept, scan, drain, commit, and the next request
// is taken only once the previous one has committed; with zero capacity the block
// goes from accept straight to commit.
//
// the response sits in an output register; while it is stalled the block holds
// the next request's write-back and response until the register frees up.
// reset empties the cache, clears the use stamp and sets the capacity to 16;
// there is no clearing pass, the valid bits are flip-flops.
module lfu_cache_table import lfu_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [CAP_W-1:0] cfg_wr_data,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	cmd_t cmd;
	status_t sts;

	lfu_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.sts(sts),
		.cmd(cmd)
	);

	lfu_dp #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req(req),
		.cmd(cmd),
		.sts(sts),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

endmodule
